@@ rtl/rsput_pkg.sv @@
// ----------------------------------------------------------------------------
// rsput_pkg
// Shared widths, codes and reset values for the range-sum tree.
// ----------------------------------------------------------------------------
package rsput_pkg;

    localparam int POS_W = 13;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;

    localparam logic [POS_W-1:0] N_USED_RESET = 13'd4096;

    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

endpackage

@@ rtl/rsput_ram.sv @@
// ----------------------------------------------------------------------------
// rsput_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsput_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/rsput_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsput_ctrl
// Sequencer: clearing pass, range-sum walk and leaf-to-root update walk.
// ----------------------------------------------------------------------------
module rsput_ctrl
    import rsput_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096,
    parameter int LW            = 12,
    parameter int IW            = 13
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [POS_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [POS_W-1:0]        bound_a,
    input  logic [POS_W-1:0]        bound_b,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] new_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] range_sum,
    output logic                    node_we,
    output logic [IW-1:0]           node_waddr,
    output logic [SUM_W-1:0]        node_wdata,
    output logic                    node_re,
    output logic [IW-1:0]           node_raddr,
    input  logic [SUM_W-1:0]        node_rdata,
    output logic                    leaf_we,
    output logic [LW-1:0]           leaf_waddr,
    output logic [VAL_W-1:0]        leaf_wdata,
    output logic                    leaf_re,
    output logic [LW-1:0]           leaf_raddr,
    input  logic [VAL_W-1:0]        leaf_rdata
);

    localparam int RW       = IW + 1;
    localparam int MAX_CLIP = (MAX_POSITIONS > 8191) ? 8191 : MAX_POSITIONS;
    localparam logic [POS_W-1:0] MAX_CLIP_V = POS_W'(MAX_CLIP);
    localparam logic [IW-1:0]    CLR_LAST   = IW'(2 * MAX_POSITIONS - 1);
    localparam logic [IW-1:0]    LEAF_END   = IW'(MAX_POSITIONS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_QOUT,
        S_UREAD,
        S_UDIF,
        S_UWALK
    } state_t;

    state_t              state_reg;
    logic [IW-1:0]       clr_reg;
    logic [POS_W-1:0]    n_used_reg;
    logic [RW-1:0]       l_reg;
    logic [RW-1:0]       r_reg;
    logic                pend_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                upd_reg;
    logic [IW-1:0]       k_reg;
    logic [LW-1:0]       leaf_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [SUM_W-1:0]    dif_reg;
    logic                out_valid_reg;
    logic [SUM_W-1:0]    range_sum_reg;

    logic [POS_W-1:0]    n_eff;
    logic [POS_W-1:0]    lo_raw;
    logic [POS_W-1:0]    hi_raw;
    logic [POS_W-1:0]    lo_c;
    logic [POS_W-1:0]    hi_c;
    logic                q_empty;
    logic                pos_ok;
    logic [RW-1:0]       l_start;
    logic [RW-1:0]       r_start;
    logic [IW-1:0]       k_start;
    logic [LW-1:0]       leaf_start;
    logic                in_xfer;
    logic                q_go;
    logic                q_rd;
    logic [RW-1:0]       r_dec;
    logic [SUM_W-1:0]    val_sx;
    logic [SUM_W-1:0]    old_sx;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign range_sum = range_sum_reg;

    always_comb
    begin
        n_eff      = (n_used_reg > MAX_CLIP_V) ? MAX_CLIP_V : n_used_reg;
        lo_raw     = (bound_a < bound_b) ? bound_a : bound_b;
        hi_raw     = (bound_a < bound_b) ? bound_b : bound_a;
        lo_c       = (lo_raw == '0) ? POS_W'(1) : lo_raw;
        hi_c       = (hi_raw > n_eff) ? n_eff : hi_raw;
        q_empty    = (lo_c > hi_c);
        pos_ok     = (position != '0) && (position <= n_eff);
        l_start    = RW'(MAX_POSITIONS) + RW'(lo_c) - RW'(1);
        r_start    = RW'(MAX_POSITIONS) + RW'(hi_c);
        k_start    = IW'(MAX_POSITIONS) + IW'(position) - IW'(1);
        leaf_start = LW'(position - POS_W'(1));
        q_go       = (l_reg < r_reg);
        q_rd       = (state_reg == S_QUERY) && q_go && (l_reg[0] || r_reg[0]);
        r_dec      = r_reg - RW'(1);
        val_sx     = {{(SUM_W-VAL_W){val_reg[VAL_W-1]}}, val_reg};
        old_sx     = {{(SUM_W-VAL_W){leaf_rdata[VAL_W-1]}}, leaf_rdata};
    end

    // memory port control
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = clr_reg;
        node_wdata = '0;
        node_re    = 1'b0;
        node_raddr = k_reg;
        leaf_we    = 1'b0;
        leaf_waddr = clr_reg[LW-1:0];
        leaf_wdata = '0;
        leaf_re    = 1'b0;
        leaf_raddr = leaf_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                node_we = 1'b1;
                leaf_we = (clr_reg < LEAF_END);
            end
            S_QUERY:
            begin
                node_re    = q_rd;
                node_raddr = l_reg[0] ? l_reg[IW-1:0] : r_dec[IW-1:0];
            end
            S_UREAD:
            begin
                node_re = 1'b1;
                leaf_re = 1'b1;
            end
            S_UDIF:
            begin
                leaf_we    = 1'b1;
                leaf_waddr = leaf_reg;
                leaf_wdata = val_reg;
            end
            S_UWALK:
            begin
                node_we    = 1'b1;
                node_waddr = k_reg;
                node_wdata = node_rdata + dif_reg;
                node_re    = (k_reg != IW'(1));
                node_raddr = k_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            n_used_reg    <= N_USED_RESET;
            l_reg         <= '0;
            r_reg         <= '0;
            pend_reg      <= 1'b0;
            sum_reg       <= '0;
            upd_reg       <= 1'b0;
            k_reg         <= '0;
            leaf_reg      <= '0;
            val_reg       <= '0;
            dif_reg       <= '0;
            out_valid_reg <= 1'b0;
            range_sum_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                n_used_reg <= cfg_data;
            end

            pend_reg <= q_rd;
            if (pend_reg)
            begin
                sum_reg <= sum_reg + node_rdata;
            end

            // in S_QOUT a taken result is replaced by the next one below
            if (out_valid_reg && out_ready && (state_reg != S_QOUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        upd_reg  <= pos_ok;
                        k_reg    <= k_start;
                        leaf_reg <= leaf_start;
                        val_reg  <= new_value;
                        l_reg    <= l_start;
                        r_reg    <= r_start;
                        sum_reg  <= '0;
                        if (func == FUNC_QUERY)
                        begin
                            state_reg <= q_empty ? S_QOUT : S_QUERY;
                        end
                        else if (pos_ok)
                        begin
                            state_reg <= S_UREAD;
                        end
                    end
                end
                S_QUERY:
                begin
                    if (!q_go)
                    begin
                        state_reg <= S_QOUT;
                    end
                    else if (l_reg[0])
                    begin
                        l_reg <= l_reg + RW'(1);
                    end
                    else if (r_reg[0])
                    begin
                        r_reg <= r_dec;
                    end
                    else
                    begin
                        l_reg <= l_reg >> 1;
                        r_reg <= r_reg >> 1;
                    end
                end
                S_QOUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        range_sum_reg <= sum_reg;
                        state_reg     <= upd_reg ? S_UREAD : S_IDLE;
                    end
                end
                S_UREAD:
                begin
                    state_reg <= S_UDIF;
                end
                S_UDIF:
                begin
                    dif_reg   <= val_sx - old_sx;
                    state_reg <= S_UWALK;
                end
                S_UWALK:
                begin
                    k_reg <= k_reg >> 1;
                    if (k_reg == IW'(1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/range_sum_point_update_tree.sv @@
// ----------------------------------------------------------------------------
// range_sum_point_update_tree
// Segment tree of 64-bit partial sums with point assignment and range query.
// ----------------------------------------------------------------------------
// Positions 1..n_used (at most MAX_POSITIONS) hold signed 32-bit values; node
// sums wrap modulo 2^64. After reset the block runs a clearing pass over all
// 2*MAX_POSITIONS node addresses before in_ready rises; cfg writes are taken
// throughout. One item is processed at a time. An assignment does a leaf
// read, a difference step, then one read-modify-write per tree level up to
// the root. A query adds a walk up the tree, with each node read through the
// single read port of the node-sum RAM, and a load of the result. A result
// waiting in the output register does not block the next transfer until the
// next query result is ready.
module range_sum_point_update_tree
    import rsput_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [POS_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [POS_W-1:0]        bound_a,
    input  logic [POS_W-1:0]        bound_b,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] new_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] range_sum
);

    localparam int LW = $clog2(MAX_POSITIONS);
    localparam int IW = $clog2(2 * MAX_POSITIONS);

    logic             node_we;
    logic [IW-1:0]    node_waddr;
    logic [SUM_W-1:0] node_wdata;
    logic             node_re;
    logic [IW-1:0]    node_raddr;
    logic [SUM_W-1:0] node_rdata;
    logic             leaf_we;
    logic [LW-1:0]    leaf_waddr;
    logic [VAL_W-1:0] leaf_wdata;
    logic             leaf_re;
    logic [LW-1:0]    leaf_raddr;
    logic [VAL_W-1:0] leaf_rdata;

    rsput_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .LW            (LW),
        .IW            (IW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .bound_a    (bound_a),
        .bound_b    (bound_b),
        .position   (position),
        .new_value  (new_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .range_sum  (range_sum),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_re    (node_re),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .leaf_we    (leaf_we),
        .leaf_waddr (leaf_waddr),
        .leaf_wdata (leaf_wdata),
        .leaf_re    (leaf_re),
        .leaf_raddr (leaf_raddr),
        .leaf_rdata (leaf_rdata)
    );

    rsput_ram #(
        .WIDTH (SUM_W),
        .DEPTH (2 * MAX_POSITIONS),
        .AW    (IW)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    rsput_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_POSITIONS),
        .AW    (LW)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .re    (leaf_re),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

endmodule

@@ tb/sv/range_sum_point_update_tree_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_checker
// Watches the item and result transfers of the range-sum tree. It keeps its
// own copy of the position values and of n_used. Every range sum is checked
// against a direct sum over the clipped range.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_checker
    import rsput_pkg::*;
#(
    parameter int MAX_POSITIONS = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [POS_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    func,
    input  logic [POS_W-1:0]        bound_a,
    input  logic [POS_W-1:0]        bound_b,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] new_value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [SUM_W-1:0] range_sum,
    output int                      errors,
    output int                      due,
    output int                      checked
);

    logic signed [VAL_W-1:0] slot_value [MAX_POSITIONS];
    logic [POS_W-1:0]        limit_reg;
    logic signed [SUM_W-1:0] sums_due [$];

    // n_used above the store size behaves as the store size
    function automatic int unsigned live_count();
        return (limit_reg > MAX_POSITIONS) ? MAX_POSITIONS : limit_reg;
    endfunction

    function automatic logic signed [SUM_W-1:0] span_total(input logic [POS_W-1:0] a,
                                                            input logic [POS_W-1:0] b);
        int unsigned lo;
        int unsigned hi;
        logic signed [SUM_W-1:0] acc;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (lo < 1)
            lo = 1;
        if (hi > live_count())
            hi = live_count();
        acc = '0;
        for (int unsigned p = lo; p <= hi; p++)
            acc = acc + slot_value[p - 1];
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [SUM_W-1:0] want;
        if (!rst_n)
        begin
            foreach (slot_value[i])
                slot_value[i] = '0;
            limit_reg = N_USED_RESET;
            sums_due.delete();
            errors  <= 0;
            due     <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $display("%0t: range_sum transfer with none due, expected none, actual %0d",
                             $time, range_sum);
                    errors <= errors + 1;
                end
                else
                begin
                    want = sums_due.pop_front();
                    checked <= checked + 1;
                    if (range_sum !== want)
                    begin
                        $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                                 $time, want, range_sum);
                        errors <= errors + 1;
                    end
                end
            end
            // query is answered before the assignment of the same item
            if (in_valid && in_ready)
            begin
                if (func == FUNC_QUERY)
                    sums_due.push_back(span_total(bound_a, bound_b));
                if (position >= 1 && position <= live_count())
                    slot_value[position - 1] = new_value;
            end
            // a write at this edge applies from the next transfer on
            if (cfg_write)
                limit_reg = cfg_data;
            due <= sums_due.size();
        end
    end

endmodule

@@ tb/sv/range_sum_point_update_tree_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_sum_point_update_tree_tb
// Drives assign and query-then-assign items into the range-sum tree under a
// series of n_used settings, with random gaps on both channels. A checker
// beside the block predicts and compares every range sum.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_tb;
    import rsput_pkg::*;

    localparam int MAX_POSITIONS  = 4096;
    localparam int POS_TOP        = (1 << POS_W) - 1;
    localparam int PHASE_ITEMS    = 118;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 30000;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [POS_W-1:0]        cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    func      = FUNC_ASSIGN;
    logic [POS_W-1:0]        bound_a   = '0;
    logic [POS_W-1:0]        bound_b   = '0;
    logic [POS_W-1:0]        position  = '0;
    logic signed [VAL_W-1:0] new_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SUM_W-1:0] range_sum;

    int errors;
    int due;
    int checked;
    int items_sent       = 0;
    int settings_written = 0;
    int quiet_cycles     = 0;
    bit in_idle_on       = 1'b1;
    bit out_idle_on      = 1'b1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    range_sum_point_update_tree #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .bound_a   (bound_a),
        .bound_b   (bound_b),
        .position  (position),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .range_sum (range_sum)
    );

    range_sum_point_update_tree_checker #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .bound_a   (bound_a),
        .bound_b   (bound_b),
        .position  (position),
        .new_value (new_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .range_sum (range_sum),
        .errors    (errors),
        .due       (due),
        .checked   (checked)
    );

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial
    begin : result_sink
        int stall;
        @(negedge clk);
        forever
        begin
            stall = out_idle_on ? $urandom_range(0, 7) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic f, input logic [POS_W-1:0] a,
                             input logic [POS_W-1:0] b, input logic [POS_W-1:0] p,
                             input logic signed [VAL_W-1:0] v);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        bound_a   <= a;
        bound_b   <= b;
        position  <= p;
        new_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_until_done();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due != 0)
            @(negedge clk);
    endtask

    task automatic set_limit(input int unsigned n);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= POS_W'(n);
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_written++;
    endtask

    function automatic logic [POS_W-1:0] pick_index(input int unsigned n_eff);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (n_eff == 0 || r == 0)
            return POS_W'($urandom_range(0, POS_TOP));
        if (r == 1)
            return POS_W'(n_eff);
        if (r == 2)
            return POS_W'(1);
        if (r == 3)
            return POS_W'($urandom_range(n_eff + 1, POS_TOP));
        return POS_W'($urandom_range(1, n_eff));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(input int unsigned n, input int count);
        int unsigned n_eff;
        int          pause_at;
        n_eff    = (n > MAX_POSITIONS) ? MAX_POSITIONS : n;
        pause_at = $urandom_range(count / 4, 3 * count / 4);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (i == pause_at)
                hold_until_done();
            send_item($urandom_range(0, 1) ? FUNC_QUERY : FUNC_ASSIGN,
                      pick_index(n_eff), pick_index(n_eff), pick_index(n_eff),
                      pick_value());
        end
    endtask

    initial
    begin : stimulus
        int unsigned plan [10];
        plan = '{4096, 100, 4096, 0, 1, 8191, 2, 4097, 4095, 0};
        plan[9] = $urandom_range(3, 300);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_limit(MAX_POSITIONS);
        send_item(FUNC_ASSIGN, 0, 0, 1, 32'sh7FFF_FFFF);
        send_item(FUNC_ASSIGN, 0, 0, 4096, 32'sh8000_0000);
        send_item(FUNC_ASSIGN, 0, 0, 2, -32'sd1);
        send_item(FUNC_QUERY, 1, 4096, 0, 32'sd55);
        send_item(FUNC_QUERY, 4096, 1, 4097, 32'sd1234);
        send_item(FUNC_QUERY, 0, 0, 8191, 32'sh7FFF_FFFF);
        send_item(FUNC_QUERY, 8191, 8191, 3, 32'sh1234_5678);
        send_item(FUNC_QUERY, 0, 8191, 3, 32'sh8000_0000);
        send_item(FUNC_QUERY, 3, 3, 3, 32'sd0);
        send_item(FUNC_QUERY, 2, 2, 4095, -32'sd2);
        send_item(FUNC_QUERY, 4095, 4096, 4096, 32'sh7FFF_FFFF);
        send_item(FUNC_QUERY, 1, 1, 1, 32'sh8000_0000);
        send_item(FUNC_QUERY, 1, 4096, 1, 32'sh7FFF_FFFF);
        send_item(FUNC_QUERY, 13'h1555, 13'h0AAA, 13'h0AAA, 32'sh5555_5555);
        send_item(FUNC_QUERY, 13'h0AAA, 13'h1555, 13'h1555, 32'shAAAA_AAAA);
        send_item(FUNC_QUERY, 1, 4096, 4096, 32'sd0);
        send_item(FUNC_QUERY, 4096, 4096, 2, 32'sd0);
        send_item(FUNC_QUERY, 1, 4096, 4095, 32'sd1);

        // lowering then raising n_used must hide and restore stored values
        foreach (plan[k])
        begin
            hold_until_done();
            repeat (SETTLE_CYCLES) @(negedge clk);
            set_limit(plan[k]);
            random_items(plan[k], PHASE_ITEMS);
        end

        hold_until_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Run covered %0d item transfers under %0d n_used writes",
                 items_sent, settings_written);
        $display("(0, 1, 4096, 8191 among them); %0d range sums compared against a %s",
                 checked, "direct sum of the stored values.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
